// ===== hdl/cdte_pkg.sv =====
package cdte_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int WORD_W      = 40;
    localparam int CNT_W       = 3;

    localparam logic [7:0] INT_BIAS    = 8'd139;
    localparam logic [7:0] POS_PREFIX  = 8'd247;
    localparam logic [7:0] NEG_PREFIX  = 8'd251;
    localparam logic [7:0] SHORT_INT   = 8'd28;
    localparam logic [7:0] LONG_INT    = 8'd29;
    localparam logic [7:0] ESCAPE_OP   = 8'd12;
    localparam logic [10:0] TWO_BYTE_BASE = 11'd108;

    localparam logic signed [32:0] ONE_MAX  = 33'sd107;
    localparam logic signed [32:0] ONE_MIN  = -33'sd107;
    localparam logic signed [32:0] TWO_MIN  = 33'sd108;
    localparam logic signed [32:0] TWO_MAX  = 33'sd1131;
    localparam logic signed [32:0] NTWO_MAX = -33'sd108;
    localparam logic signed [32:0] NTWO_MIN = -33'sd1131;
    localparam logic signed [32:0] SHORT_MAX = 33'sd32767;
    localparam logic signed [32:0] SHORT_MIN = -33'sd32768;

    localparam logic [2:0] OFFSET_SIZE_RESET = 3'd1;

    typedef enum logic [1:0] {
        CMD_INT = 2'd0,
        CMD_OP  = 2'd1,
        CMD_OFF = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  count;
    } t_tok;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// ===== hdl/cdte_front.sv =====
module cdte_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_data,
    input  logic [1:0]          i_command,
    input  logic signed [32:0]  i_value,
    output cdte_pkg::t_tok      o_tok
);

    logic [2:0]          r_offset_size;
    logic signed [32:0]  v;
    logic [10:0]         m_pos;
    logic [10:0]         m_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_size <= cdte_pkg::OFFSET_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_offset_size <= i_cfg_data;
        end
    end

    assign v     = i_value;
    assign m_pos = i_value[10:0] - cdte_pkg::TWO_BYTE_BASE;
    // -v - 108 == ~v - 107
    assign m_neg = (~i_value[10:0]) - (cdte_pkg::TWO_BYTE_BASE - 11'd1);

    always_comb begin
        o_tok = '0;
        unique case (cdte_pkg::t_cmd'(i_command))
            cdte_pkg::CMD_INT: begin
                priority if (v >= cdte_pkg::ONE_MIN && v <= cdte_pkg::ONE_MAX) begin
                    o_tok.word  = {i_value[7:0] + cdte_pkg::INT_BIAS, 32'd0};
                    o_tok.count = 3'd1;
                end else if (v >= cdte_pkg::TWO_MIN && v <= cdte_pkg::TWO_MAX) begin
                    o_tok.word  = {cdte_pkg::POS_PREFIX + {6'd0, m_pos[9:8]},
                                   m_pos[7:0], 24'd0};
                    o_tok.count = 3'd2;
                end else if (v >= cdte_pkg::NTWO_MIN && v <= cdte_pkg::NTWO_MAX) begin
                    o_tok.word  = {cdte_pkg::NEG_PREFIX + {6'd0, m_neg[9:8]},
                                   m_neg[7:0], 24'd0};
                    o_tok.count = 3'd2;
                end else if (v >= cdte_pkg::SHORT_MIN && v <= cdte_pkg::SHORT_MAX) begin
                    o_tok.word  = {cdte_pkg::SHORT_INT, i_value[15:0], 16'd0};
                    o_tok.count = 3'd3;
                end else begin
                    o_tok.word  = {cdte_pkg::LONG_INT, i_value[31:0]};
                    o_tok.count = 3'd5;
                end
            end
            cdte_pkg::CMD_OP: begin
                if (i_value[15:8] == cdte_pkg::ESCAPE_OP) begin
                    o_tok.word  = {i_value[15:0], 24'd0};
                    o_tok.count = 3'd2;
                end else begin
                    o_tok.word  = {i_value[7:0], 32'd0};
                    o_tok.count = 3'd1;
                end
            end
            cdte_pkg::CMD_OFF: begin
                unique case (r_offset_size)
                    3'd1: o_tok.word = {i_value[7:0], 32'd0};
                    3'd2: o_tok.word = {i_value[15:0], 24'd0};
                    3'd3: o_tok.word = {i_value[23:0], 16'd0};
                    3'd4: o_tok.word = {i_value[31:0], 8'd0};
                    default: o_tok.word = '0;
                endcase
                // sizes outside 1..4 emit nothing
                o_tok.count = (r_offset_size >= 3'd1 && r_offset_size <= 3'd4) ?
                              r_offset_size : 3'd0;
            end
            default: o_tok = '0;
        endcase
    end

endmodule

// ===== hdl/cdte_queue.sv =====
module cdte_queue #(
    parameter int DEPTH = cdte_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  cdte_pkg::t_tok   i_wdata,
    input  logic             i_rd,
    output cdte_pkg::t_tok   o_rdata,
    output cdte_pkg::t_qstat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cdte_pkg::t_tok r_mem [DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_count, n_count;
    logic           do_wr, do_rd;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign do_wr        = i_wr && !o_stat.full;
    assign do_rd        = i_rd && !o_stat.empty;
    assign o_rdata      = r_mem[r_rp];

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (do_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        n_count = r_count + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count missed a write");

endmodule

// ===== hdl/cdte_back.sv =====
module cdte_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cdte_pkg::t_tok   i_head,
    input  cdte_pkg::t_qstat i_qstat,
    output logic             o_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_byte,
    output logic             o_last
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = !i_qstat.empty && (!r_valid || i_pop);
    assign is_last = (r_idx == i_head.count - 3'd1);
    assign o_rd    = load && is_last;

    always_comb begin
        unique case (r_idx)
            3'd0:    sel_byte = i_head.word[39:32];
            3'd1:    sel_byte = i_head.word[31:24];
            3'd2:    sel_byte = i_head.word[23:16];
            3'd3:    sel_byte = i_head.word[15:8];
            3'd4:    sel_byte = i_head.word[7:0];
            default: sel_byte = '0;
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = is_last ? 3'd0 : r_idx + 3'd1;
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= is_last;
        end
    end

    assign o_empty = !r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    a_idx_in_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_qstat.empty |-> (r_idx < i_head.count))
        else $error("byte index beyond token length");

    a_head_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_qstat.empty |-> (i_head.count != 3'd0))
        else $error("empty token queued");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !is_last) |=> (r_idx == $past(r_idx) + 3'd1))
        else $error("byte index did not advance");

    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd |=> (r_idx == 3'd0) && r_valid && r_last)
        else $error("token end not flagged");

endmodule

// ===== hdl/cff_dict_token_encoder.sv =====
// channel  | handshake           | payload
// ---------+---------------------+------------------------------
// input    | push / full         | i_command[1:0], i_value[32:0]
// result   | pop / empty         | o_out_byte[7:0], o_last
// config   | i_cfg_we            | i_cfg_data[2:0] (offset_size)
//
// A token of k bytes (1..5) leaves one byte a cycle while pop is high, so it holds
// the byte serialiser to its last byte; the serialiser sets the sustained rate.
// The first byte is registered in the token queue and then in the result register.
// Tokens that emit no bytes are dropped at the input and never enter the queue.
// Synchronous reset empties the token queue and result register; offset_size = 1.
// full is raised only while the token queue is full; the queue absorbs pop stalls.
module cff_dict_token_encoder #(
    parameter int QUEUE_DEPTH = cdte_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_command,
    input  logic signed [32:0] i_value,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);

    cdte_pkg::t_tok   tok;
    cdte_pkg::t_tok   head;
    cdte_pkg::t_qstat qstat;
    logic             q_wr;
    logic             q_rd;

    cdte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_command  (i_command),
        .i_value    (i_value),
        .o_tok      (tok)
    );

    assign full = qstat.full;
    assign q_wr = push && !qstat.full && (tok.count != '0);

    cdte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (tok),
        .i_rd    (q_rd),
        .o_rdata (head),
        .o_stat  (qstat)
    );

    cdte_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_rd    (q_rd),
        .i_pop   (pop),
        .o_empty (empty),
        .o_byte  (o_out_byte),
        .o_last  (o_last)
    );

endmodule

// ===== dv/tb.sv =====
module tb;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
    } t_byte_exp;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_cfg_we   = 1'b0;
    logic [2:0]         i_cfg_data = '0;
    logic               push       = 1'b0;
    logic               full;
    logic [1:0]         i_command  = '0;
    logic signed [32:0] i_value    = '0;
    logic               empty;
    logic               pop        = 1'b0;
    logic [7:0]         o_out_byte;
    logic               o_last;

    t_byte_exp  expected_bytes[$];
    logic [2:0] offset_size_copy = cdte_pkg::OFFSET_SIZE_RESET;
    logic       no_idle          = 1'b0;
    int         pop_hold         = 0;
    int         tokens_sent      = 0;
    int         bytes_checked    = 0;
    int         mismatches       = 0;

    cff_dict_token_encoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_command  (i_command),
        .i_value    (i_value),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic predict_token(input logic [1:0] cmd, input logic signed [32:0] val);
        logic [39:0] word;
        logic [32:0] m;
        int          n;
        t_byte_exp   e;
        word = '0;
        n    = 0;
        case (cmd)
            cdte_pkg::CMD_INT: begin
                if (val >= cdte_pkg::ONE_MIN && val <= cdte_pkg::ONE_MAX) begin
                    word = 40'(val[7:0] + cdte_pkg::INT_BIAS);
                    n    = 1;
                end else if (val >= cdte_pkg::TWO_MIN && val <= cdte_pkg::TWO_MAX) begin
                    m    = val - cdte_pkg::TWO_MIN;
                    word = {24'd0, cdte_pkg::POS_PREFIX + 8'(m[9:8]), m[7:0]};
                    n    = 2;
                end else if (val >= cdte_pkg::NTWO_MIN && val <= cdte_pkg::NTWO_MAX) begin
                    m    = cdte_pkg::NTWO_MAX - val;
                    word = {24'd0, cdte_pkg::NEG_PREFIX + 8'(m[9:8]), m[7:0]};
                    n    = 2;
                end else if (val >= cdte_pkg::SHORT_MIN && val <= cdte_pkg::SHORT_MAX) begin
                    word = {16'd0, cdte_pkg::SHORT_INT, val[15:0]};
                    n    = 3;
                end else begin
                    word = {cdte_pkg::LONG_INT, val[31:0]};
                    n    = 5;
                end
            end
            cdte_pkg::CMD_OP: begin
                if (val[15:8] == cdte_pkg::ESCAPE_OP) begin
                    word = {24'd0, val[15:0]};
                    n    = 2;
                end else begin
                    word = {32'd0, val[7:0]};
                    n    = 1;
                end
            end
            cdte_pkg::CMD_OFF: begin
                if (offset_size_copy >= 3'd1 && offset_size_copy <= 3'd4) begin
                    word = {8'd0, val[31:0]};
                    n    = int'(offset_size_copy);
                end
            end
            default: n = 0;
        endcase
        for (int i = 0; i < n; i++) begin
            e.out_byte = word[8*(n-1-i) +: 8];
            e.last     = (i == n - 1);
            expected_bytes.push_back(e);
        end
    endtask

    // push stays high between back-to-back items; only idle_cycles and drain lower it
    task automatic send_token(input logic [1:0] cmd, input logic signed [32:0] val);
        i_command <= cmd;
        i_value   <= val;
        push      <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_token(cmd, val);
        tokens_sent++;
    endtask

    task automatic idle_cycles(input int n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (!no_idle && $urandom_range(5, 0) == 0) idle_cycles(int'($urandom_range(16, 1)));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_offset_size(input logic [2:0] size);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        offset_size_copy  = size;
    endtask

    function automatic logic signed [32:0] rand_value();
        logic signed [32:0] v;
        int                 r;
        case ($urandom_range(5, 0))
            0: begin r = $urandom_range(214, 0);   v = 33'(r - 107);   end
            1: begin r = $urandom_range(1023, 0);  v = 33'(r + 108);   end
            2: begin r = $urandom_range(1023, 0);  v = 33'(-108 - r);  end
            3: begin r = $urandom_range(65535, 0); v = 33'(r - 32768); end
            default: begin
                v[31:0] = $urandom();
                v[32]   = 1'($urandom_range(1, 0));
            end
        endcase
        return v;
    endfunction

    function automatic logic [1:0] rand_command();
        int r;
        r = $urandom_range(15, 0);
        if (r < 7)  return cdte_pkg::CMD_INT;
        if (r < 11) return cdte_pkg::CMD_OP;
        if (r < 15) return cdte_pkg::CMD_OFF;
        return CMD_UNKNOWN;
    endfunction

    function automatic logic signed [32:0] rand_operator();
        logic signed [32:0] v;
        v[31:0] = $urandom();
        v[32]   = 1'($urandom_range(1, 0));
        if ($urandom_range(1, 0)) v[15:8] = cdte_pkg::ESCAPE_OP;
        return v;
    endfunction

    task automatic test_integer_bands();
        logic signed [32:0] vals[14];
        vals = '{33'sd0, 33'sd107, -33'sd107, 33'sd108, 33'sd1131, -33'sd108, -33'sd1131,
                 33'sd32767, -33'sd32768, 33'sd1132, -33'sd32769,
                 33'sh0_7FFF_FFFF, 33'sh0_FFFF_FFFF, 33'sh1_0000_0000};
        foreach (vals[i]) send_token(cdte_pkg::CMD_INT, vals[i]);
    endtask

    task automatic test_operators();
        send_token(cdte_pkg::CMD_OP, 33'sh0_0000_0C05);
        send_token(cdte_pkg::CMD_OP, 33'sh0_0000_0015);
        send_token(cdte_pkg::CMD_OP, 33'sh1_FFFF_0CFF);
        send_token(cdte_pkg::CMD_OP, 33'sh1_5555_FFFF);
        send_token(CMD_UNKNOWN, 33'sh1_FFFF_FFFF);
        send_token(CMD_UNKNOWN, 33'sh0_0000_0000);
    endtask

    // sizes 0 and 5..7 drop the token
    task automatic test_offset_sizes();
        for (int s = 0; s < 8; s++) begin
            set_offset_size(3'(s));
            send_token(cdte_pkg::CMD_OFF, 33'sh1_89AB_CDEF);
        end
    endtask

    task automatic test_random_tokens();
        logic [2:0]         sizes[6];
        logic [1:0]         cmd;
        logic signed [32:0] val;
        sizes = '{3'd4, 3'd1, 3'd3, 3'd0, 3'd2, 3'd7};
        foreach (sizes[p]) begin
            set_offset_size(sizes[p]);
            repeat (45) begin
                cmd = rand_command();
                case (cmd)
                    cdte_pkg::CMD_INT: val = rand_value();
                    cdte_pkg::CMD_OP:  val = rand_operator();
                    default: begin
                        val[31:0] = $urandom();
                        val[32]   = 1'($urandom_range(1, 0));
                    end
                endcase
                send_token(cmd, val);
                maybe_gap();
            end
        end
    endtask

    task automatic test_streaming();
        logic [1:0]         cmd;
        logic signed [32:0] val;
        set_offset_size(3'd4);
        no_idle = 1'b1;
        repeat (60) begin
            cmd = rand_command();
            val = (cmd == cdte_pkg::CMD_OP) ? rand_operator() : rand_value();
            send_token(cmd, val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (no_idle) begin
            pop <= 1'b1;
        end else if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else if ($urandom_range(7, 0) == 0) begin
            pop_hold <= int'($urandom_range(15, 0));
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_byte_exp e;
        if (i_rst_n && pop && !empty) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte %0d (last %0d)", o_out_byte, o_last);
                mismatches++;
            end else begin
                e = expected_bytes.pop_front();
                bytes_checked++;
                if (o_out_byte !== e.out_byte) begin
                    $error("out_byte: expected %0d, got %0d", e.out_byte, o_out_byte);
                    mismatches++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_integer_bands();
        test_operators();
        test_offset_sizes();
        test_random_tokens();
        test_streaming();
        drain();
        if (expected_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            mismatches++;
        end
        $display("%0d tokens sent, %0d bytes checked, %0d mismatches",
                 tokens_sent, bytes_checked, mismatches);
        $display("covered all integer bands, operators, unknown commands, offset sizes 0-7");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
